### hw/rtl/qvm_pkg.sv
// shared widths, types and rounding functions for the quaternion view matrix
package qvm_pkg;

    localparam int QUAT_W         = 16;
    localparam int QUAT_FRAC_BITS = 15;
    localparam int POS_W          = 32;
    localparam int MAT_W          = 18;
    localparam int TRANS_W        = 32;

    localparam int PROD_W     = 2 * QUAT_W;
    localparam int EXACT_W    = PROD_W + 3;
    localparam int RND_W      = EXACT_W + 1 - QUAT_FRAC_BITS;
    localparam int DOT_PROD_W = MAT_W + POS_W;
    localparam int DOT_W      = DOT_PROD_W + 2;
    localparam int DOT_RND_W  = DOT_W + 1 - QUAT_FRAC_BITS;

    localparam int IN_DATA_W  = ((4 * QUAT_W + 3 * POS_W + 7) / 8) * 8;
    localparam int OUT_BITS   = 9 * MAT_W + 3 * TRANS_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic signed [EXACT_W-1:0] MAT_ONE =
        EXACT_W'(1) << (2 * QUAT_FRAC_BITS);
    localparam logic signed [EXACT_W:0] MAT_HALF =
        (EXACT_W + 1)'(1) << (QUAT_FRAC_BITS - 1);
    localparam logic signed [DOT_W:0] DOT_HALF =
        (DOT_W + 1)'(1) << (QUAT_FRAC_BITS - 1);

    localparam logic signed [MAT_W-1:0] MAT_MAX = {1'b0, {(MAT_W - 1){1'b1}}};
    localparam logic signed [MAT_W-1:0] MAT_MIN = {1'b1, {(MAT_W - 1){1'b0}}};
    localparam logic signed [TRANS_W-1:0] TRANS_MAX = {1'b0, {(TRANS_W - 1){1'b1}}};
    localparam logic signed [TRANS_W-1:0] TRANS_MIN = {1'b1, {(TRANS_W - 1){1'b0}}};

    typedef struct packed {
        logic signed [PROD_W-1:0] aa;
        logic signed [PROD_W-1:0] bb;
        logic signed [PROD_W-1:0] cc;
        logic signed [PROD_W-1:0] ab;
        logic signed [PROD_W-1:0] ac;
        logic signed [PROD_W-1:0] bc;
        logic signed [PROD_W-1:0] sa;
        logic signed [PROD_W-1:0] sb;
        logic signed [PROD_W-1:0] sc;
    } prod_t;

    // load enables of the three translation stages
    typedef struct packed {
        logic mul;
        logic sum;
        logic fin;
    } dot_ld_t;

    // round half up to QUAT_FRAC_BITS fraction bits and saturate to a matrix entry
    function automatic logic signed [MAT_W-1:0] mat_round(
        input logic signed [EXACT_W-1:0] x
    );
        logic signed [EXACT_W:0] rnd;
        logic signed [RND_W-1:0] q;
        rnd = (EXACT_W + 1)'(x) + MAT_HALF;
        q = $signed(rnd[EXACT_W:QUAT_FRAC_BITS]);
        if (q > RND_W'(MAT_MAX))
            return MAT_MAX;
        else if (q < RND_W'(MAT_MIN))
            return MAT_MIN;
        else
            return q[MAT_W-1:0];
    endfunction

    // negate the dot product, round half up, drop the matrix fraction, saturate
    function automatic logic signed [TRANS_W-1:0] trans_round(
        input logic signed [DOT_W-1:0] dot
    );
        logic signed [DOT_W:0] rnd;
        logic signed [DOT_RND_W-1:0] q;
        rnd = -((DOT_W + 1)'(dot)) + DOT_HALF;
        q = $signed(rnd[DOT_W:QUAT_FRAC_BITS]);
        if (q > DOT_RND_W'(TRANS_MAX))
            return TRANS_MAX;
        else if (q < DOT_RND_W'(TRANS_MIN))
            return TRANS_MIN;
        else
            return q[TRANS_W-1:0];
    endfunction

endpackage

### hw/rtl/qvm_dot_row.sv
// one translation row: three products, their sum, then negate, round and saturate
module qvm_dot_row (
    input  logic                                 clk,
    input  qvm_pkg::dot_ld_t                     ld,
    input  logic signed [qvm_pkg::MAT_W-1:0]     ent_x,
    input  logic signed [qvm_pkg::MAT_W-1:0]     ent_y,
    input  logic signed [qvm_pkg::MAT_W-1:0]     ent_z,
    input  logic signed [qvm_pkg::POS_W-1:0]     pos_x,
    input  logic signed [qvm_pkg::POS_W-1:0]     pos_y,
    input  logic signed [qvm_pkg::POS_W-1:0]     pos_z,
    output logic signed [qvm_pkg::TRANS_W-1:0]   trans
);
    import qvm_pkg::*;

    logic signed [DOT_PROD_W-1:0] px_reg;
    logic signed [DOT_PROD_W-1:0] py_reg;
    logic signed [DOT_PROD_W-1:0] pz_reg;
    logic signed [DOT_W-1:0]      dot_reg;
    logic signed [TRANS_W-1:0]    trans_reg;

    always_ff @(posedge clk)
    begin
        if (ld.mul)
        begin
            px_reg <= DOT_PROD_W'(ent_x) * DOT_PROD_W'(pos_x);
            py_reg <= DOT_PROD_W'(ent_y) * DOT_PROD_W'(pos_y);
            pz_reg <= DOT_PROD_W'(ent_z) * DOT_PROD_W'(pos_z);
        end
        if (ld.sum)
        begin
            dot_reg <= DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
        end
        if (ld.fin)
        begin
            trans_reg <= trans_round(dot_reg);
        end
    end

    assign trans = trans_reg;

endmodule

### hw/rtl/quaternion_view_matrix.sv
// view matrix from a camera quaternion and position, five register stages
// throughput: one pose per cycle; a stalled output holds only the stages behind it
// stages: quaternion products, matrix entries, row products, row sums, translation
// reset clears the stage valid bits only; data registers are not reset
module quaternion_view_matrix (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // quat_scalar, quat_a, quat_b, quat_c, pos_x, pos_y, pos_z
    input  logic [qvm_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // side_x, side_y, side_z, up_x, up_y, up_z, fwd_x, fwd_y, fwd_z,
    // trans_x, trans_y, trans_z, zero pad
    output logic [qvm_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import qvm_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] ready;

    logic signed [QUAT_W-1:0] in_s;
    logic signed [QUAT_W-1:0] in_a;
    logic signed [QUAT_W-1:0] in_b;
    logic signed [QUAT_W-1:0] in_c;

    prod_t                    prod_reg;
    logic signed [POS_W-1:0]  pos1_reg [3];
    logic signed [POS_W-1:0]  pos2_reg [3];
    logic signed [MAT_W-1:0]  mat2_reg [9];
    logic signed [MAT_W-1:0]  mat3_reg [9];
    logic signed [MAT_W-1:0]  mat4_reg [9];
    logic signed [MAT_W-1:0]  mat5_reg [9];
    logic signed [MAT_W-1:0]  mat_next [9];
    logic signed [TRANS_W-1:0] trans [3];
    dot_ld_t                  dot_ld;

    // a stage takes new data when empty or when the stage after it moves
    always_comb
    begin
        ready[NSTG-1] = !valid_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--)
            ready[k] = !valid_reg[k] || ready[k+1];
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
                valid_reg[0] <= s_tvalid;
            for (int k = 1; k < NSTG; k++)
                if (ready[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    assign in_s = $signed(s_tdata[QUAT_W-1:0]);
    assign in_a = $signed(s_tdata[2*QUAT_W-1:QUAT_W]);
    assign in_b = $signed(s_tdata[3*QUAT_W-1:2*QUAT_W]);
    assign in_c = $signed(s_tdata[4*QUAT_W-1:3*QUAT_W]);

    // exact entries with twice the fraction bits, then round and saturate
    always_comb
    begin
        mat_next[0] = mat_round(MAT_ONE - ((EXACT_W'(prod_reg.bb) + EXACT_W'(prod_reg.cc)) <<< 1));
        mat_next[1] = mat_round((EXACT_W'(prod_reg.ab) + EXACT_W'(prod_reg.sc)) <<< 1);
        mat_next[2] = mat_round((EXACT_W'(prod_reg.ac) - EXACT_W'(prod_reg.sb)) <<< 1);
        mat_next[3] = mat_round((EXACT_W'(prod_reg.ab) - EXACT_W'(prod_reg.sc)) <<< 1);
        mat_next[4] = mat_round(MAT_ONE - ((EXACT_W'(prod_reg.aa) + EXACT_W'(prod_reg.cc)) <<< 1));
        mat_next[5] = mat_round((EXACT_W'(prod_reg.bc) + EXACT_W'(prod_reg.sa)) <<< 1);
        mat_next[6] = mat_round((EXACT_W'(prod_reg.ac) + EXACT_W'(prod_reg.sb)) <<< 1);
        mat_next[7] = mat_round((EXACT_W'(prod_reg.bc) - EXACT_W'(prod_reg.sa)) <<< 1);
        mat_next[8] = mat_round(MAT_ONE - ((EXACT_W'(prod_reg.aa) + EXACT_W'(prod_reg.bb)) <<< 1));
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            prod_reg.aa <= PROD_W'(in_a) * PROD_W'(in_a);
            prod_reg.bb <= PROD_W'(in_b) * PROD_W'(in_b);
            prod_reg.cc <= PROD_W'(in_c) * PROD_W'(in_c);
            prod_reg.ab <= PROD_W'(in_a) * PROD_W'(in_b);
            prod_reg.ac <= PROD_W'(in_a) * PROD_W'(in_c);
            prod_reg.bc <= PROD_W'(in_b) * PROD_W'(in_c);
            prod_reg.sa <= PROD_W'(in_s) * PROD_W'(in_a);
            prod_reg.sb <= PROD_W'(in_s) * PROD_W'(in_b);
            prod_reg.sc <= PROD_W'(in_s) * PROD_W'(in_c);
            for (int i = 0; i < 3; i++)
                pos1_reg[i] <= $signed(s_tdata[4*QUAT_W + i*POS_W +: POS_W]);
        end
        if (ready[1])
        begin
            mat2_reg <= mat_next;
            pos2_reg <= pos1_reg;
        end
        if (ready[2])
            mat3_reg <= mat2_reg;
        if (ready[3])
            mat4_reg <= mat3_reg;
        if (ready[4])
            mat5_reg <= mat4_reg;
    end

    assign dot_ld.mul = ready[2];
    assign dot_ld.sum = ready[3];
    assign dot_ld.fin = ready[4];

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        qvm_dot_row u_row (
            .clk   (clk),
            .ld    (dot_ld),
            .ent_x (mat2_reg[3*r]),
            .ent_y (mat2_reg[3*r+1]),
            .ent_z (mat2_reg[3*r+2]),
            .pos_x (pos2_reg[0]),
            .pos_y (pos2_reg[1]),
            .pos_z (pos2_reg[2]),
            .trans (trans[r])
        );
    end

    always_comb
    begin
        m_tdata = '0;
        for (int i = 0; i < 9; i++)
            m_tdata[i*MAT_W +: MAT_W] = mat5_reg[i];
        for (int i = 0; i < 3; i++)
            m_tdata[9*MAT_W + i*TRANS_W +: TRANS_W] = trans[i];
    end

`ifndef NO_ASSERTIONS
    localparam logic signed [MAT_W-1:0] DIAG_MAX = MAT_W'(1) << QUAT_FRAC_BITS;

    // an empty output register must never hold back the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    // a stalled matrix stage keeps its item and its diagonal entries
    a_mat_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] && !ready[1] |=> valid_reg[1] && $stable(mat2_reg[0])
            && $stable(mat2_reg[4]) && $stable(mat2_reg[8]))
        else $error("stalled matrix stage changed");

    // diagonal entries are one minus a sum of squares, so never above one
    a_diag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> mat5_reg[0] <= DIAG_MAX && mat5_reg[4] <= DIAG_MAX
            && mat5_reg[8] <= DIAG_MAX)
        else $error("diagonal entry above one");
`endif

endmodule
